// ===== rtl/core/ttu_pkg.sv =====
package ttu_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned DELTA_W = 33;
  localparam int unsigned PROD_W  = 51;
  localparam int unsigned ACC_W   = 68;
  localparam int unsigned LO_W    = 17;
  localparam int unsigned FRAC_W  = 16;

  localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

  // accumulator targets
  localparam logic [1:0] ACC_DET = 2'd0;
  localparam logic [1:0] ACC_NX  = 2'd1;
  localparam logic [1:0] ACC_NY  = 2'd2;
  localparam logic [1:0] ACC_NZ  = 2'd3;

  // tangent components
  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  // corner slots
  localparam logic [1:0] CORNER_0 = 2'd0;
  localparam logic [1:0] CORNER_1 = 2'd1;
  localparam logic [1:0] CORNER_2 = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_DINIT = 6'b000100,
    ST_DRUN  = 6'b001000,
    ST_DDONE = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  typedef struct packed {
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       mul_half;
    logic       acc_en;
    logic       div_init;
    logic       div_step;
    logic       div_done;
    logic [1:0] comp;
    logic       deg_set;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
  } status_t;

endpackage

// ===== rtl/core/ttu_if.sv =====
interface ttu_in_if;
  import ttu_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] pos_x;
  logic [DATA_W-1:0] pos_y;
  logic [DATA_W-1:0] pos_z;
  logic [DATA_W-1:0] tex_u;
  logic [DATA_W-1:0] tex_v;
  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface ttu_out_if;
  import ttu_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] tangent_x;
  logic [DATA_W-1:0] tangent_y;
  logic [DATA_W-1:0] tangent_z;
  logic              degenerate;
  logic              saturated;
  modport source (output valid, tangent_x, tangent_y, tangent_z, degenerate, saturated,
                  input ready);
  modport sink   (input valid, tangent_x, tangent_y, tangent_z, degenerate, saturated,
                  output ready);
endinterface

// ===== rtl/core/triangle_tangent_unit.sv =====
// Triangle tangent unit.
// in_ch takes one triangle corner per transfer: position and texture
// coordinate, signed Q16.16. The first two corners of a triangle are held;
// the third starts the tangent computation and yields one transfer on
// out_ch with the unnormalized tangent, a degenerate flag (zero UV
// determinant, tangent zero) and a saturated flag.
// First and second corner: in_ch.ready stays high.
// Third corner: multiply-accumulate on one 33x18 multiplier
// (eight exact products, two halves each), then per component a setup
// step, 32 restoring divide steps and a finish step, then the output
// register is loaded; the divides are skipped when the determinant is zero.
// in_ch.ready is low while a triangle is being worked on.
// The output register holds its result until taken; new corners are
// accepted while it waits, but the next triangle's result waits until the
// previous one is transferred.
// Synchronous active-low reset clears the corner count and the output valid.
module triangle_tangent_unit
  import ttu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ttu_in_if.sink    in_ch,
  ttu_out_if.source out_ch
);

  cmd_t    cmd;
  status_t status;

  ttu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ttu_dp u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .status         (status),
    .in_pos_x       (in_ch.pos_x),
    .in_pos_y       (in_ch.pos_y),
    .in_pos_z       (in_ch.pos_z),
    .in_tex_u       (in_ch.tex_u),
    .in_tex_v       (in_ch.tex_v),
    .out_tangent_x  (out_ch.tangent_x),
    .out_tangent_y  (out_ch.tangent_y),
    .out_tangent_z  (out_ch.tangent_z),
    .out_degenerate (out_ch.degenerate),
    .out_saturated  (out_ch.saturated)
  );

endmodule

// ===== rtl/core/ttu_ctrl.sv =====
module ttu_ctrl
  import ttu_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] corner_r, corner_nxt;
  logic [4:0] step_r, step_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_xfer;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign in_xfer   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    corner_nxt    = corner_r;
    step_nxt      = step_r;
    comp_nxt      = comp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.comp      = comp_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd.cap_en  = 1'b1;
          cmd.cap_sel = corner_r;
          if (corner_r == CORNER_2) begin
            corner_nxt = CORNER_0;
            step_nxt   = '0;
            state_nxt  = ST_MUL;
          end else begin
            corner_nxt = corner_r + 2'd1;
          end
        end
      end
      ST_MUL: begin
        // product issued one step, accumulated the next
        cmd.mul_en   = !step_r[4];
        cmd.mul_sel  = step_r[3:1];
        cmd.mul_half = step_r[0];
        cmd.acc_en   = (step_r != '0);
        step_nxt     = step_r + 5'd1;
        if (step_r[4]) begin
          comp_nxt  = COMP_X;
          state_nxt = ST_DINIT;
        end
      end
      ST_DINIT: begin
        if (status.det_zero) begin
          cmd.deg_set = 1'b1;
          state_nxt   = ST_EMIT;
        end else begin
          cmd.div_init = 1'b1;
          step_nxt     = '0;
          state_nxt    = ST_DRUN;
        end
      end
      ST_DRUN: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 5'd1;
        if (step_r == 5'd31) state_nxt = ST_DDONE;
      end
      ST_DDONE: begin
        cmd.div_done = 1'b1;
        if (comp_r == COMP_Z) begin
          state_nxt = ST_EMIT;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = ST_DINIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      corner_r    <= CORNER_0;
      step_r      <= '0;
      comp_r      <= COMP_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      corner_r    <= corner_nxt;
      step_r      <= step_nxt;
      comp_r      <= comp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/ttu_dp.sv =====
module ttu_dp
  import ttu_pkg::*;
(
  input  logic              clk,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic [DATA_W-1:0] in_pos_x,
  input  logic [DATA_W-1:0] in_pos_y,
  input  logic [DATA_W-1:0] in_pos_z,
  input  logic [DATA_W-1:0] in_tex_u,
  input  logic [DATA_W-1:0] in_tex_v,
  output logic [DATA_W-1:0] out_tangent_x,
  output logic [DATA_W-1:0] out_tangent_y,
  output logic [DATA_W-1:0] out_tangent_z,
  output logic              out_degenerate,
  output logic              out_saturated
);

  logic [DATA_W-1:0] p0x_r, p0y_r, p0z_r, u0_r, v0_r;
  logic [DATA_W-1:0] p1x_r, p1y_r, p1z_r, u1_r, v1_r;
  logic signed [DELTA_W-1:0] dx1_r, dx2_r, dy1_r, dy2_r, dz1_r, dz2_r;
  logic signed [DELTA_W-1:0] s1_r, s2_r, t1_r, t2_r;
  logic signed [ACC_W-1:0] det_r, nx_r, ny_r, nz_r;
  logic signed [ACC_W-1:0] preg_r;
  logic [1:0]              tgt_r;
  logic                    sub_r;

  logic [ACC_W-1:0]   rem_r;
  logic [DATA_W-1:0]  q_r;
  logic [DATA_W-1:0]  nbits_r;
  logic               ovf_r;
  logic               nneg_r;

  logic [DATA_W-1:0] res_x_r, res_y_r, res_z_r;
  logic              deg_r, sat_r;
  logic [DATA_W-1:0] tx_r, ty_r, tz_r;
  logic              odeg_r, osat_r;

  function automatic logic signed [DELTA_W-1:0] sdiff(input logic [DATA_W-1:0] a,
                                                      input logic [DATA_W-1:0] b);
    sdiff = $signed({a[DATA_W-1], a}) - $signed({b[DATA_W-1], b});
  endfunction

  // multiplier operand select
  logic signed [DELTA_W-1:0] op_a, op_b;
  logic signed [LO_W:0]      op_bm;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   prod_ext;

  always_comb begin
    case (cmd.mul_sel)
      3'd0:    begin op_a = s1_r; op_b = t2_r;  end
      3'd1:    begin op_a = s2_r; op_b = t1_r;  end
      3'd2:    begin op_a = t2_r; op_b = dx1_r; end
      3'd3:    begin op_a = t1_r; op_b = dx2_r; end
      3'd4:    begin op_a = t2_r; op_b = dy1_r; end
      3'd5:    begin op_a = t1_r; op_b = dy2_r; end
      3'd6:    begin op_a = t2_r; op_b = dz1_r; end
      default: begin op_a = t1_r; op_b = dz2_r; end
    endcase
    // low half unsigned 17 bits, high half signed 16 bits
    if (cmd.mul_half) op_bm = $signed({{2{op_b[DELTA_W-1]}}, op_b[DELTA_W-1:LO_W]});
    else              op_bm = $signed({1'b0, op_b[LO_W-1:0]});
    prod     = op_a * op_bm;
    prod_ext = ACC_W'(prod);
    if (cmd.mul_half) prod_ext = prod_ext <<< LO_W;
  end

  logic signed [ACC_W-1:0] addend;
  assign addend = sub_r ? -preg_r : preg_r;

  // division setup
  logic [ACC_W-1:0]        dm;
  logic signed [ACC_W-1:0] num;
  logic [ACC_W-1:0]        nm;
  logic [ACC_W:0]          rem2;
  logic [ACC_W:0]          rem_sub;
  logic                    q_bit;

  assign dm = det_r[ACC_W-1] ? ACC_W'(-det_r) : ACC_W'(det_r);

  always_comb begin
    case (cmd.comp)
      COMP_X:  num = nx_r;
      COMP_Y:  num = ny_r;
      default: num = nz_r;
    endcase
    nm      = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
    rem2    = {rem_r, nbits_r[DATA_W-1]};
    rem_sub = rem2 - {1'b0, dm};
    q_bit   = !rem_sub[ACC_W];
  end

  // component finish
  logic              cneg;
  logic [DATA_W-1:0] cval;
  logic              csat;

  always_comb begin
    cneg = (nneg_r != det_r[ACC_W-1]) && (ovf_r || (q_r != '0));
    csat = 1'b0;
    if (!cneg) begin
      if (ovf_r || q_r > SAT_POS) begin
        csat = 1'b1;
        cval = SAT_POS;
      end else begin
        cval = q_r;
      end
    end else begin
      if (ovf_r || q_r > SAT_NEG) begin
        csat = 1'b1;
        cval = SAT_NEG;
      end else begin
        cval = -q_r;
      end
    end
  end

  assign status.det_zero = (det_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      case (cmd.cap_sel)
        CORNER_0: begin
          p0x_r <= in_pos_x; p0y_r <= in_pos_y; p0z_r <= in_pos_z;
          u0_r  <= in_tex_u; v0_r  <= in_tex_v;
        end
        CORNER_1: begin
          p1x_r <= in_pos_x; p1y_r <= in_pos_y; p1z_r <= in_pos_z;
          u1_r  <= in_tex_u; v1_r  <= in_tex_v;
        end
        default: begin
          dx1_r <= sdiff(p1x_r, p0x_r); dx2_r <= sdiff(in_pos_x, p0x_r);
          dy1_r <= sdiff(p1y_r, p0y_r); dy2_r <= sdiff(in_pos_y, p0y_r);
          dz1_r <= sdiff(p1z_r, p0z_r); dz2_r <= sdiff(in_pos_z, p0z_r);
          s1_r  <= sdiff(u1_r, u0_r);   s2_r  <= sdiff(in_tex_u, u0_r);
          t1_r  <= sdiff(v1_r, v0_r);   t2_r  <= sdiff(in_tex_v, v0_r);
          det_r <= '0; nx_r <= '0; ny_r <= '0; nz_r <= '0;
          deg_r <= 1'b0; sat_r <= 1'b0;
          res_x_r <= '0; res_y_r <= '0; res_z_r <= '0;
        end
      endcase
    end

    if (cmd.mul_en) begin
      preg_r <= prod_ext;
      tgt_r  <= cmd.mul_sel[2:1];
      sub_r  <= cmd.mul_sel[0];
    end

    if (cmd.acc_en) begin
      case (tgt_r)
        ACC_DET: det_r <= det_r + addend;
        ACC_NX:  nx_r  <= nx_r + addend;
        ACC_NY:  ny_r  <= ny_r + addend;
        default: nz_r  <= nz_r + addend;
      endcase
    end

    if (cmd.div_init) begin
      nneg_r  <= num[ACC_W-1];
      // quotient of 2^32 or more cannot fit
      ovf_r   <= ({{FRAC_W{1'b0}}, nm} >= {dm, {FRAC_W{1'b0}}});
      rem_r   <= nm >> FRAC_W;
      nbits_r <= {nm[FRAC_W-1:0], {FRAC_W{1'b0}}};
      q_r     <= '0;
    end else if (cmd.div_step) begin
      rem_r   <= q_bit ? rem_sub[ACC_W-1:0] : rem2[ACC_W-1:0];
      nbits_r <= nbits_r << 1;
      q_r     <= {q_r[DATA_W-2:0], q_bit};
    end

    if (cmd.div_done) begin
      sat_r <= sat_r | csat;
      case (cmd.comp)
        COMP_X:  res_x_r <= cval;
        COMP_Y:  res_y_r <= cval;
        default: res_z_r <= cval;
      endcase
    end

    if (cmd.deg_set) deg_r <= 1'b1;

    if (cmd.out_load) begin
      tx_r   <= res_x_r;
      ty_r   <= res_y_r;
      tz_r   <= res_z_r;
      odeg_r <= deg_r;
      osat_r <= sat_r;
    end
  end

  assign out_tangent_x  = tx_r;
  assign out_tangent_y  = ty_r;
  assign out_tangent_z  = tz_r;
  assign out_degenerate = odeg_r;
  assign out_saturated  = osat_r;

endmodule

// ===== rtl/core/ttu_checker.sv =====
module ttu_checker
  import ttu_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] tangent_x,
  input logic [DATA_W-1:0] tangent_y,
  input logic [DATA_W-1:0] tangent_z,
  input logic              degenerate,
  input logic              saturated
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && degenerate |->
      tangent_x == '0 && tangent_y == '0 && tangent_z == '0 && !saturated)
    else $error("degenerate result not zero");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |->
      tangent_x == SAT_POS || tangent_x == SAT_NEG ||
      tangent_y == SAT_POS || tangent_y == SAT_NEG ||
      tangent_z == SAT_POS || tangent_z == SAT_NEG)
    else $error("saturated without a bound value");

  a_busy_after_res: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_ready) == 1'b0)
    else $error("result appeared without computation");

endmodule

bind triangle_tangent_unit ttu_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .tangent_x  (out_ch.tangent_x),
  .tangent_y  (out_ch.tangent_y),
  .tangent_z  (out_ch.tangent_z),
  .degenerate (out_ch.degenerate),
  .saturated  (out_ch.saturated)
);
